@@ src/mdpi_pkg.sv @@
// Shared types, constants and register codes for the mecanum drive PI controller.
// Used by every module of the block; depends on nothing else.
package mdpi_pkg;

	localparam int WHEELS      = 4;
	localparam int VEL_W       = 16;
	localparam int ENC_W       = 16;
	localparam int GAIN_W      = 16;
	localparam int LIM_W       = 14;
	localparam int DUTY_W      = 14;
	localparam int ACC_W       = 15;
	localparam int BIAS_W      = 17;
	localparam int ROT_W       = 33;
	localparam int SUM_W       = 36;
	localparam int PD_W        = 35;
	localparam int IB_W        = 34;
	localparam int TOT_W       = 37;
	localparam int TGT_SHIFT   = 22;
	localparam int ACC_SHIFT   = 8;
	localparam int LIN_SHIFT   = 14;
	localparam int IN_W        = 112;
	localparam int OUT_W       = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int QUEUE_DEPTH = 4;

	// Per-wheel sign pattern of the kinematics and of the direction flag.
	localparam logic [WHEELS-1:0] X_NEG   = 4'b0101;
	localparam logic [WHEELS-1:0] Z_NEG   = 4'b0110;
	localparam logic [WHEELS-1:0] REV_POS = 4'b1100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP   = 3'd0,
		REG_KI   = 3'd1,
		REG_GEO  = 3'd2,
		REG_ILIM = 3'd3,
		REG_OLIM = 3'd4
	} reg_idx_t;

	localparam logic [GAIN_W-1:0] KP_RESET   = 16'd2560;
	localparam logic [GAIN_W-1:0] KI_RESET   = 16'd2560;
	localparam logic [GAIN_W-1:0] GEO_RESET  = 16'd10133;
	localparam logic [LIM_W-1:0]  ILIM_RESET = 14'd7200;
	localparam logic [LIM_W-1:0]  OLIM_RESET = 14'd6900;

	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] geo;
		logic [LIM_W-1:0]  ilim;
		logic [LIM_W-1:0]  olim;
	} cfg_t;

	typedef logic [WHEELS-1:0][BIAS_W-1:0] bias_vec_t;

endpackage

@@ src/mdpi_front.sv @@
// Front end: inverse kinematics and per-wheel speed error.
// Two pipeline stages with their own stall chain; uses mdpi_pkg.
module mdpi_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [mdpi_pkg::IN_W-1:0] in_data,
	input  logic [mdpi_pkg::GAIN_W-1:0] geo,
	output logic                      out_valid,
	input  logic                      out_ready,
	output mdpi_pkg::bias_vec_t       out_bias
);
	import mdpi_pkg::*;

	logic                    valid_s1, valid_s2;
	logic                    ready_s1, ready_s2;
	logic signed [VEL_W-1:0] vx_s1, vy_s1;
	logic signed [ROT_W-1:0] rot_s1;
	logic signed [ENC_W-1:0] enc_s1 [WHEELS];
	logic signed [ENC_W-1:0] enc_s2 [WHEELS];
	logic signed [SUM_W-1:0] sum_s2 [WHEELS];

	assign ready_s2  = !valid_s2 || out_ready;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign in_ready  = ready_s1;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			vx_s1  <= $signed(in_data[VEL_W-1:0]);
			vy_s1  <= $signed(in_data[2*VEL_W-1:VEL_W]);
			rot_s1 <= $signed(in_data[3*VEL_W-1:2*VEL_W]) * $signed({1'b0, geo});
			for (int w = 0; w < WHEELS; w++) begin
				enc_s1[w] <= $signed(in_data[3*VEL_W + w*ENC_W +: ENC_W]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			for (int w = 0; w < WHEELS; w++) begin
				logic signed [VEL_W+1:0] lin;
				logic signed [SUM_W-1:0] rot_term;
				lin = X_NEG[w] ? (-(VEL_W+2)'(vx_s1) + (VEL_W+2)'(vy_s1))
				               : ((VEL_W+2)'(vx_s1) + (VEL_W+2)'(vy_s1));
				rot_term = Z_NEG[w] ? -SUM_W'(rot_s1) : SUM_W'(rot_s1);
				sum_s2[w] <= (SUM_W'(lin) <<< LIN_SHIFT) + rot_term;
				enc_s2[w] <= enc_s1[w];
			end
		end
	end

	// Division by 2^22 rounds toward zero, so negative sums get a bias first.
	always_comb begin
		for (int w = 0; w < WHEELS; w++) begin
			logic signed [SUM_W-1:0] tgt;
			logic signed [SUM_W-1:0] diff;
			tgt = (sum_s2[w] + (sum_s2[w][SUM_W-1] ? SUM_W'((1 << TGT_SHIFT) - 1)
			                                        : SUM_W'(0))) >>> TGT_SHIFT;
			diff = SUM_W'(enc_s2[w]) - tgt;
			out_bias[w] = diff[BIAS_W-1:0];
		end
	end

endmodule

@@ src/mdpi_queue.sv @@
// Short queue of per-wheel errors between the front and back ends.
// Flip-flop storage with read and write pointers; uses mdpi_pkg.
module mdpi_queue #(
	parameter int DEPTH = mdpi_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mdpi_pkg::bias_vec_t in_bias,
	output logic                out_valid,
	input  logic                out_ready,
	output mdpi_pkg::bias_vec_t out_bias
);
	import mdpi_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bias_vec_t         entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push, pop;

	assign in_ready  = (count_q != CNT_W'(DEPTH));
	assign out_valid = (count_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_bias  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= in_bias;
	end

endmodule

@@ src/mdpi_back.sv @@
// Back end: four incremental PI lanes, output clamp and output register.
// Holds the accumulator and previous error of each wheel; uses mdpi_pkg.
module mdpi_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  mdpi_pkg::bias_vec_t        in_bias,
	input  mdpi_pkg::cfg_t             cfg,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [mdpi_pkg::OUT_W-1:0] out_data
);
	import mdpi_pkg::*;

	logic                     valid_s1, valid_s2, out_valid_q;
	logic                     ready_s1, ready_s2, out_ready_int;
	logic signed [BIAS_W-1:0] prev_q [WHEELS];
	logic signed [ACC_W-1:0]  acc_q  [WHEELS];
	logic signed [PD_W-1:0]   pd_s1  [WHEELS];
	logic signed [IB_W-1:0]   ib_s1  [WHEELS];
	logic signed [ACC_W-1:0]  acc_next [WHEELS];
	logic [OUT_W-1:0]         out_q;
	logic [OUT_W-1:0]         out_next;

	assign out_ready_int = !out_valid_q || out_ready;
	assign ready_s2      = !valid_s2 || out_ready_int;
	assign ready_s1      = !valid_s1 || ready_s2;
	assign in_ready      = ready_s1;
	assign out_valid     = out_valid_q;
	assign out_data      = out_q;

	// The accumulator register doubles as the second stage: it takes a new
	// value exactly when a transaction moves from the multiplier stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int w = 0; w < WHEELS; w++) begin
				prev_q[w] <= '0;
				acc_q[w]  <= '0;
			end
		end else begin
			if (ready_s1)      valid_s1    <= in_valid;
			if (ready_s2)      valid_s2    <= valid_s1;
			if (out_ready_int) out_valid_q <= valid_s2;
			for (int w = 0; w < WHEELS; w++) begin
				if (ready_s1 && in_valid) prev_q[w] <= $signed(in_bias[w]);
				if (ready_s2 && valid_s1) acc_q[w]  <= acc_next[w];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			for (int w = 0; w < WHEELS; w++) begin
				logic signed [BIAS_W:0] delta;
				delta = (BIAS_W+1)'($signed(in_bias[w])) - (BIAS_W+1)'(prev_q[w]);
				pd_s1[w] <= delta * $signed({1'b0, cfg.kp});
				ib_s1[w] <= $signed(in_bias[w]) * $signed({1'b0, cfg.ki});
			end
		end
		if (out_ready_int && valid_s2) out_q <= out_next;
	end

	always_comb begin
		for (int w = 0; w < WHEELS; w++) begin
			logic signed [TOT_W-1:0] total;
			logic signed [TOT_W-1:0] quot;
			logic signed [TOT_W-1:0] lim;
			total = (TOT_W'(acc_q[w]) <<< ACC_SHIFT) + TOT_W'(pd_s1[w]) + TOT_W'(ib_s1[w]);
			quot  = (total + (total[TOT_W-1] ? TOT_W'((1 << ACC_SHIFT) - 1)
			                                 : TOT_W'(0))) >>> ACC_SHIFT;
			lim   = TOT_W'($signed({1'b0, cfg.ilim}));
			if (quot > lim)       acc_next[w] = lim[ACC_W-1:0];
			else if (quot < -lim) acc_next[w] = ACC_W'(-lim);
			else                  acc_next[w] = quot[ACC_W-1:0];
		end
	end

	always_comb begin
		out_next = '0;
		for (int w = 0; w < WHEELS; w++) begin
			logic signed [ACC_W-1:0] lim;
			logic signed [ACC_W-1:0] drive;
			logic signed [ACC_W-1:0] mag;
			logic                    rev;
			lim = $signed({1'b0, cfg.olim});
			if (acc_q[w] > lim)       drive = lim;
			else if (acc_q[w] < -lim) drive = -lim;
			else                      drive = acc_q[w];
			mag = drive[ACC_W-1] ? -drive : drive;
			rev = REV_POS[w] ? (!drive[ACC_W-1] && (drive != '0)) : drive[ACC_W-1];
			out_next[w*(DUTY_W+1) +: DUTY_W+1] = {rev, mag[DUTY_W-1:0]};
		end
	end

endmodule

@@ src/mecanum_drive_pi_controller.sv @@
// Top level of the mecanum drive PI controller: configuration registers and
// the front end, queue and back end; uses mdpi_pkg and the mdpi_* modules.
//
// One control tick per transaction: a body velocity command and four wheel
// counts go in, four drive magnitudes with direction bits come out. The block
// takes one transaction every clock cycle unless stalled; a result passes
// through the two front stages, the queue, the multiplier stage, the
// accumulator stage and the output register, and the wheel accumulators carry
// over from each transaction to the next. The queue between the front and back
// ends lets either side stall on its own. The user must write gains, geometry
// and limits through the configuration channel only while no transaction is
// in flight; the block does not enforce this. Out-of-range indexes are ignored.
module mecanum_drive_pi_controller #(
	parameter int QUEUE_DEPTH = mdpi_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// vel_x, vel_y, vel_z, enc_a, enc_b, enc_c, enc_d, 16 bits each
	input  logic [mdpi_pkg::IN_W-1:0]       s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// duty_a, rev_a, duty_b, rev_b, duty_c, rev_c, duty_d, rev_d, then 4 zero bits
	output logic [mdpi_pkg::OUT_W-1:0]      m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mdpi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mdpi_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mdpi_pkg::*;

	cfg_t      cfg_q;
	logic      fq_valid, fq_ready, qb_valid, qb_ready;
	bias_vec_t fq_bias, qb_bias;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp   <= KP_RESET;
			cfg_q.ki   <= KI_RESET;
			cfg_q.geo  <= GEO_RESET;
			cfg_q.ilim <= ILIM_RESET;
			cfg_q.olim <= OLIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_KP:   cfg_q.kp   <= cfg_data;
				REG_KI:   cfg_q.ki   <= cfg_data;
				REG_GEO:  cfg_q.geo  <= cfg_data;
				REG_ILIM: cfg_q.ilim <= cfg_data[LIM_W-1:0];
				REG_OLIM: cfg_q.olim <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	mdpi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.geo       (cfg_q.geo),
		.out_valid (fq_valid),
		.out_ready (fq_ready),
		.out_bias  (fq_bias)
	);

	mdpi_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_bias   (fq_bias),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_bias  (qb_bias)
	);

	mdpi_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (qb_valid),
		.in_ready  (qb_ready),
		.in_bias   (qb_bias),
		.cfg       (cfg_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

@@ tb/mecanum_drive_checker.sv @@
// Checker for the mecanum drive PI controller: watches the tick, result and register
// channels, predicts each wheel's drive and compares it with the block's output.
// Depends on mdpi_pkg for widths, sign patterns, register codes and reset values.
`timescale 1ns / 100ps

module mecanum_drive_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [mdpi_pkg::IN_W-1:0]       s_tdata,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [mdpi_pkg::OUT_W-1:0]      m_tdata,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [mdpi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mdpi_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              mismatches,
	output int                              results_checked
);
	import mdpi_pkg::*;

	localparam int LANE_W = DUTY_W + 1;

	typedef struct packed {
		logic [WHEELS-1:0][DUTY_W-1:0] duty;
		logic [WHEELS-1:0]             rev;
	} drive_set_t;

	cfg_t       setup;
	longint     acc_state [WHEELS];
	longint     prev_bias [WHEELS];
	drive_set_t expected_drives [$];
	int         error_tally = 0;
	int         match_tally = 0;

	assign mismatches      = error_tally;
	assign results_checked = match_tally;

	function automatic longint clamp_sym(input longint v, input longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// Runs one control tick through the kinematics and the four PI lanes,
	// updating the lane state, and returns the drive the block should send.
	function automatic drive_set_t advance_wheels(input logic [IN_W-1:0] tick);
		drive_set_t drives;
		longint vx, vy, vz, rot, lin, target, bias, acc, drv;
		vx  = longint'($signed(tick[0 +: VEL_W]));
		vy  = longint'($signed(tick[VEL_W +: VEL_W]));
		vz  = longint'($signed(tick[2*VEL_W +: VEL_W]));
		rot = vz * longint'(setup.geo);
		for (int w = 0; w < WHEELS; w++) begin
			lin    = ((X_NEG[w] ? -vx : vx) + vy) * (longint'(1) << LIN_SHIFT);
			// Signed division truncates toward zero, as the target requires.
			target = (Z_NEG[w] ? lin - rot : lin + rot) / (longint'(1) << TGT_SHIFT);
			bias   = longint'($signed(tick[3*VEL_W + w*ENC_W +: ENC_W])) - target;
			acc    = acc_state[w] * (longint'(1) << ACC_SHIFT)
				+ longint'(setup.kp) * (bias - prev_bias[w])
				+ longint'(setup.ki) * bias;
			acc    = clamp_sym(acc / (longint'(1) << ACC_SHIFT), longint'(setup.ilim));
			acc_state[w] = acc;
			prev_bias[w] = bias;
			drv = clamp_sym(acc, longint'(setup.olim));
			drives.rev[w]  = REV_POS[w] ? (drv > 0) : (drv < 0);
			drives.duty[w] = DUTY_W'(drv < 0 ? -drv : drv);
		end
		return drives;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		drive_set_t want;
		logic [DUTY_W-1:0] got_duty;
		logic got_rev;
		if (!arst_n) begin
			setup = '{kp: KP_RESET, ki: KI_RESET, geo: GEO_RESET,
				ilim: ILIM_RESET, olim: OLIM_RESET};
			for (int w = 0; w < WHEELS; w++) begin
				acc_state[w] = 0;
				prev_bias[w] = 0;
			end
			expected_drives.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_KP:   setup.kp   = cfg_data;
					REG_KI:   setup.ki   = cfg_data;
					REG_GEO:  setup.geo  = cfg_data;
					REG_ILIM: setup.ilim = cfg_data[LIM_W-1:0];
					REG_OLIM: setup.olim = cfg_data[LIM_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_drives.push_back(advance_wheels(s_tdata));
			if (m_tvalid && m_tready) begin
				if (expected_drives.size() == 0) begin
					$display("%0t: result %h arrived with no tick outstanding", $time, m_tdata);
					error_tally++;
				end else begin
					want = expected_drives.pop_front();
					match_tally++;
					for (int w = 0; w < WHEELS; w++) begin
						got_duty = m_tdata[w*LANE_W +: DUTY_W];
						got_rev  = m_tdata[w*LANE_W + DUTY_W];
						if (got_duty !== want.duty[w]) begin
							$display("%0t: wheel %0d duty expected %0d, got %0d",
								$time, w, want.duty[w], got_duty);
							error_tally++;
						end
						if (got_rev !== want.rev[w]) begin
							$display("%0t: wheel %0d direction expected %0b, got %0b",
								$time, w, want.rev[w], got_rev);
							error_tally++;
						end
					end
					if (m_tdata[OUT_W-1:WHEELS*LANE_W] !== '0) begin
						$display("%0t: padding bits expected 0, got %h",
							$time, m_tdata[OUT_W-1:WHEELS*LANE_W]);
						error_tally++;
					end
				end
			end
		end
	end

endmodule

@@ tb/mecanum_drive_pi_controller_tb.sv @@
// Testbench top for the mecanum drive PI controller: clock, reset, tick and register
// stimulus with random back-pressure, and the verdict; needs mdpi_pkg, the block
// and mecanum_drive_checker.
`timescale 1ns / 100ps

module mecanum_drive_pi_controller_tb;
	import mdpi_pkg::*;

	localparam int CLK_PERIOD  = 10;
	localparam int MAX_CYCLES  = 600000;
	localparam int TAIL_CYCLES = 20;
	localparam logic [VEL_W-1:0]      FIELD_MAX = 16'h7FFF;
	localparam logic [VEL_W-1:0]      FIELD_MIN = 16'h8000;
	localparam logic [CFG_DATA_W-1:0] LIM_TOP   = 16'((1 << LIM_W) - 1);

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_W-1:0]      m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int mismatches;
	int results_checked;
	int ticks_sent    = 0;
	int cfg_writes    = 0;
	int settings_used = 1;
	int cycle_count   = 0;
	bit gaps_on       = 1'b1;

	always #(CLK_PERIOD / 2) clk = ~clk;

	mecanum_drive_pi_controller DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	mecanum_drive_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatches      (mismatches),
		.results_checked (results_checked)
	);

	// Mostly no gap or a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	function automatic logic [IN_W-1:0] make_tick(input logic [VEL_W-1:0] vx, vy, vz,
		input logic [ENC_W-1:0] ea, eb, ec, ed);
		return {ed, ec, eb, ea, vz, vy, vx};
	endfunction

	function automatic logic [VEL_W-1:0] corner_value();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return 16'd1;
			2: return '1;
			3: return FIELD_MAX;
			default: return FIELD_MIN;
		endcase
	endfunction

	// About four ticks in ten keep the wheel counts close to the commanded speeds so the lanes
	// move through their whole range instead of sitting at the clamps.
	function automatic logic [IN_W-1:0] rand_tick();
		logic [VEL_W-1:0] f [7];
		int style;
		style = $urandom_range(0, 9);
		for (int i = 0; i < 7; i++) begin
			if (style < 4)
				f[i] = (i < 3) ? 16'($urandom_range(0, 4095) - 2048)
					: 16'($urandom_range(0, 48) - 24);
			else if (style < 7)
				f[i] = 16'($urandom);
			else if (style < 9)
				f[i] = (i < 3) ? 16'($urandom) : 16'($urandom_range(0, 2000) - 1000);
			else
				f[i] = corner_value();
		end
		return make_tick(f[0], f[1], f[2], f[3], f[4], f[5], f[6]);
	endfunction

	task automatic send_tick(input logic [IN_W-1:0] tick);
		int gap;
		s_tdata  <= tick;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		ticks_sent++;
		gap = gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic random_ticks(input int count);
		for (int i = 0; i < count; i++)
			send_tick(rand_tick());
	endtask

	// Holds the sender off until every accepted tick has produced its result.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (results_checked < ticks_sent)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_writes++;
	endtask

	task automatic apply_settings(input logic [CFG_DATA_W-1:0] kp, ki, geo, ilim, olim,
		input bit probe_unused);
		drain();
		if (probe_unused)
			for (int i = int'(REG_OLIM) + 1; i < (1 << CFG_IDX_W); i++)
				write_reg(CFG_IDX_W'(i), 16'($urandom));
		write_reg(REG_KP, kp);
		write_reg(REG_KI, ki);
		write_reg(REG_GEO, geo);
		write_reg(REG_ILIM, ilim);
		write_reg(REG_OLIM, olim);
		cfg_valid <= 1'b0;
		settings_used++;
		gaps_on = ($urandom_range(0, 3) != 0);
	endtask

	task automatic random_settings();
		apply_settings(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
			16'($urandom), 16'($urandom_range(0, LIM_TOP)),
			16'($urandom_range(0, LIM_TOP)), 1'b0);
	endtask

	initial begin : result_sink
		int span;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			span = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 16);
			m_tready <= 1'b1;
			repeat (span) @(posedge clk);
			span = pick_gap();
			if (span > 0) begin
				m_tready <= 1'b0;
				repeat (span) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < MAX_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: run did not finish within %0d cycles", $time, MAX_CYCLES);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin : stimulus
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Field extremes under the reset gains and limits.
		send_tick(make_tick('0, '0, '0, '0, '0, '0, '0));
		send_tick(make_tick(FIELD_MAX, '0, '0, '0, '0, '0, '0));
		send_tick(make_tick(FIELD_MIN, '0, '0, '0, '0, '0, '0));
		send_tick(make_tick('0, FIELD_MAX, '0, '0, '0, '0, '0));
		send_tick(make_tick('0, FIELD_MIN, '0, '0, '0, '0, '0));
		send_tick(make_tick('0, '0, FIELD_MAX, '0, '0, '0, '0));
		send_tick(make_tick('0, '0, FIELD_MIN, '0, '0, '0, '0));
		send_tick(make_tick('0, '0, '0, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX));
		send_tick(make_tick('0, '0, '0, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN));
		send_tick(make_tick(FIELD_MAX, FIELD_MAX, FIELD_MAX,
			FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX));
		send_tick(make_tick(FIELD_MIN, FIELD_MIN, FIELD_MIN,
			FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN));
		send_tick(make_tick(FIELD_MIN, FIELD_MAX, FIELD_MIN,
			FIELD_MIN, FIELD_MAX, FIELD_MIN, FIELD_MAX));
		send_tick(make_tick('0, '0, '0, FIELD_MAX, '0, '0, '0));
		send_tick(make_tick('0, '0, '0, '0, FIELD_MAX, '0, '0));
		send_tick(make_tick('0, '0, '0, '0, '0, FIELD_MAX, '0));
		send_tick(make_tick('0, '0, '0, '0, '0, '0, FIELD_MAX));
		// Small negative commands check truncation toward zero.
		send_tick(make_tick('1, '0, '1, '0, '0, '0, '0));
		send_tick(make_tick(16'd256, 16'd256, 16'd256, 16'd1, 16'd1, 16'd1, 16'd1));
		send_tick(make_tick(16'd1, '1, 16'd1, '1, 16'd1, '1, 16'd1));
		send_tick(make_tick('0, '0, '0, '0, '0, '0, '0));
		send_tick(make_tick('0, '0, '0, '0, '0, '0, '0));
		random_ticks(60);

		// Reset values again, with stray upper bits on the limits and writes
		// to indexes the block does not decode.
		apply_settings(KP_RESET, KI_RESET, GEO_RESET, {2'b11, ILIM_RESET},
			{2'b10, OLIM_RESET}, 1'b1);
		random_ticks(60);
		apply_settings('1, '1, '1, LIM_TOP, LIM_TOP, 1'b0);
		random_ticks(70);
		apply_settings('0, '0, '0, '0, '0, 1'b0);
		random_ticks(40);
		apply_settings(16'($urandom_range(1, 3000)), 16'($urandom_range(1, 3000)),
			GEO_RESET, '0, LIM_TOP, 1'b0);
		random_ticks(40);
		apply_settings(KP_RESET, KI_RESET, GEO_RESET, LIM_TOP, '0, 1'b0);
		random_ticks(40);
		// Output clamp wider than the integrator clamp, so it never bites.
		apply_settings(KP_RESET, KI_RESET, GEO_RESET, 16'd500, 16'd12000, 1'b0);
		random_ticks(60);
		apply_settings(16'd1, 16'd1, 16'd1, LIM_TOP, LIM_TOP, 1'b0);
		random_ticks(60);
		random_settings();
		random_ticks(70);
		random_settings();
		random_ticks(35);
		drain();
		random_ticks(35);
		random_settings();
		random_ticks(70);
		random_settings();
		random_ticks(70);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d control ticks under %0d register settings using %0d register writes.",
			ticks_sent, settings_used, cfg_writes);
		$display("Settings included zero limits, full-scale gains and an output limit above the integrator limit.");
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
